// ----- sv/utf8d_pkg.sv -----
`default_nettype none

package utf8d_pkg;

  // Byte classes and second-byte bounds of strict UTF-8
  localparam logic [7:0] ASCII_MAX = 8'h7f;
  localparam logic [7:0] LEAD2_MIN = 8'hc2;
  localparam logic [7:0] LEAD2_MAX = 8'hdf;
  localparam logic [7:0] LEAD3_MIN = 8'he0;
  localparam logic [7:0] LEAD3_MAX = 8'hef;
  localparam logic [7:0] LEAD4_MIN = 8'hf0;
  localparam logic [7:0] LEAD4_MAX = 8'hf4;
  localparam logic [7:0] CONT_LO   = 8'h80;
  localparam logic [7:0] CONT_HI   = 8'hbf;
  localparam logic [7:0] LEAD_E0   = 8'he0;
  localparam logic [7:0] LEAD_ED   = 8'hed;
  localparam logic [7:0] LEAD_F0   = 8'hf0;
  localparam logic [7:0] LEAD_F4   = 8'hf4;
  localparam logic [7:0] E0_LO     = 8'ha0;
  localparam logic [7:0] ED_HI     = 8'h9f;
  localparam logic [7:0] F0_LO     = 8'h90;
  localparam logic [7:0] F4_HI     = 8'h8f;

  localparam logic [20:0] BMP_MAX     = 21'h00ffff;
  localparam logic [20:0] SUPP_BASE   = 21'h010000;
  localparam logic [5:0]  HI_SUR_TAG  = 6'b110110;  // 0xd800 >> 10
  localparam logic [5:0]  LO_SUR_TAG  = 6'b110111;  // 0xdc00 >> 10

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = QAW + 1;

  typedef struct packed {
    logic [15:0] unit;
    logic        status;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } dec_out_t;

endpackage

`default_nettype wire

// ----- sv/utf8d_decode.sv -----
`default_nettype none

module utf8d_decode (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               advance,
  input  wire logic [7:0]         data_byte,
  input  wire logic               end_of_string,
  output utf8d_pkg::dec_out_t     dout
);

  logic [1:0]  continuations_left, continuations_left_next;
  logic [20:0] codepoint_accum, codepoint_accum_next;
  logic [7:0]  lead_byte_held, lead_byte_held_next;
  logic        awaiting_second_byte, awaiting_second_byte_next;
  logic        discarding, discarding_next;

  logic        emit;
  logic        err;
  logic [20:0] cp;
  logic [20:0] acc_shift;
  logic [20:0] supp;
  logic [7:0]  lo;
  logic [7:0]  hi;

  assign acc_shift = {codepoint_accum[14:0], data_byte[5:0]};
  assign supp      = cp - utf8d_pkg::SUPP_BASE;

  always_comb begin
    continuations_left_next   = continuations_left;
    codepoint_accum_next      = codepoint_accum;
    lead_byte_held_next       = lead_byte_held;
    awaiting_second_byte_next = awaiting_second_byte;
    discarding_next           = discarding;
    emit = 1'b0;
    err  = 1'b0;
    cp   = acc_shift;
    lo   = utf8d_pkg::CONT_LO;
    hi   = utf8d_pkg::CONT_HI;
    dout = '0;

    if (discarding) begin
      if (end_of_string) discarding_next = 1'b0;
    end else if (continuations_left == 2'd0) begin
      unique case (data_byte) inside
        [8'h00 : utf8d_pkg::ASCII_MAX]: begin
          emit = 1'b1;
          cp   = {13'd0, data_byte};
        end
        [utf8d_pkg::LEAD2_MIN : utf8d_pkg::LEAD2_MAX]: begin
          codepoint_accum_next    = {16'd0, data_byte[4:0]};
          continuations_left_next = 2'd1;
          err = end_of_string;
        end
        [utf8d_pkg::LEAD3_MIN : utf8d_pkg::LEAD3_MAX]: begin
          codepoint_accum_next    = {17'd0, data_byte[3:0]};
          continuations_left_next = 2'd2;
          err = end_of_string;
        end
        [utf8d_pkg::LEAD4_MIN : utf8d_pkg::LEAD4_MAX]: begin
          codepoint_accum_next    = {18'd0, data_byte[2:0]};
          continuations_left_next = 2'd3;
          err = end_of_string;
        end
        default: err = 1'b1;
      endcase
      lead_byte_held_next       = data_byte;
      awaiting_second_byte_next = 1'b1;
    end else begin
      if (awaiting_second_byte) begin
        unique case (lead_byte_held)
          utf8d_pkg::LEAD_E0: lo = utf8d_pkg::E0_LO;
          utf8d_pkg::LEAD_ED: hi = utf8d_pkg::ED_HI;
          utf8d_pkg::LEAD_F0: lo = utf8d_pkg::F0_LO;
          utf8d_pkg::LEAD_F4: hi = utf8d_pkg::F4_HI;
          default: ;
        endcase
      end
      if (data_byte < lo || data_byte > hi) begin
        err = 1'b1;
      end else begin
        awaiting_second_byte_next = 1'b0;
        codepoint_accum_next      = acc_shift;
        continuations_left_next   = continuations_left - 2'd1;
        if (continuations_left == 2'd1) emit = 1'b1;
        else                            err  = end_of_string;
      end
    end

    // Both ends of a sequence drop back to idle
    if (emit || err) begin
      continuations_left_next   = 2'd0;
      codepoint_accum_next      = '0;
      lead_byte_held_next       = '0;
      awaiting_second_byte_next = 1'b0;
    end

    if (err) begin
      discarding_next    = !end_of_string;
      dout.count         = 2'd1;
      dout.first.unit    = 16'h0000;
      dout.first.status  = 1'b1;
      dout.first.last    = 1'b1;
    end else if (emit) begin
      if (cp <= utf8d_pkg::BMP_MAX) begin
        dout.count       = 2'd1;
        dout.first.unit  = cp[15:0];
        dout.first.last  = end_of_string;
      end else begin
        dout.count       = 2'd2;
        dout.first.unit  = {utf8d_pkg::HI_SUR_TAG, supp[19:10]};
        dout.first.last  = 1'b0;
        dout.second.unit = {utf8d_pkg::LO_SUR_TAG, supp[9:0]};
        dout.second.last = end_of_string;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      continuations_left   <= 2'd0;
      codepoint_accum      <= '0;
      lead_byte_held       <= '0;
      awaiting_second_byte <= 1'b0;
      discarding           <= 1'b0;
    end else if (advance) begin
      continuations_left   <= continuations_left_next;
      codepoint_accum      <= codepoint_accum_next;
      lead_byte_held       <= lead_byte_held_next;
      awaiting_second_byte <= awaiting_second_byte_next;
      discarding           <= discarding_next;
    end
  end

  // An error mid-string must start the drop phase
  assert property (@(posedge clk) disable iff (rst)
    advance && !discarding && dout.first.status && !end_of_string |=> discarding)
    else $error("error inside a string did not start discarding");

  // A pair is always a clean high surrogate followed by a low one
  assert property (@(posedge clk) disable iff (rst)
    dout.count == 2'd2 |-> !dout.first.last && !dout.first.status &&
      dout.first.unit[15:10] == utf8d_pkg::HI_SUR_TAG &&
      dout.second.unit[15:10] == utf8d_pkg::LO_SUR_TAG)
    else $error("malformed surrogate pair");

  // Nothing comes out while a string is being dropped
  assert property (@(posedge clk) disable iff (rst)
    discarding |-> dout.count == 2'd0)
    else $error("result produced while discarding");

endmodule

`default_nettype wire

// ----- sv/utf8d_outq.sv -----
`default_nettype none

module utf8d_outq (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire utf8d_pkg::dec_out_t  din,
  input  wire logic                 pop,
  output logic                      room2,
  output logic                      nonempty,
  output utf8d_pkg::result_t        head
);

  utf8d_pkg::result_t           entries [utf8d_pkg::QDEPTH];
  logic [utf8d_pkg::QAW-1:0]    wr_ptr, wr_ptr_next;
  logic [utf8d_pkg::QAW-1:0]    rd_ptr;
  logic [utf8d_pkg::QCW-1:0]    count, count_next;
  logic [1:0]                   push_cnt;

  assign push_cnt    = push ? din.count : 2'd0;
  assign wr_ptr_next = wr_ptr + utf8d_pkg::QAW'(push_cnt);
  assign count_next  = count + utf8d_pkg::QCW'(push_cnt) - utf8d_pkg::QCW'(pop);

  assign room2    = count <= utf8d_pkg::QCW'(utf8d_pkg::QDEPTH - 2);
  assign nonempty = count != '0;
  assign head     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) entries[wr_ptr] <= din.first;
    if (push_cnt == 2'd2) entries[wr_ptr + utf8d_pkg::QAW'(1)] <= din.second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      if (pop) rd_ptr <= rd_ptr + utf8d_pkg::QAW'(1);
      count  <= count_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= utf8d_pkg::QCW'(utf8d_pkg::QDEPTH))
    else $error("output queue overflow");

  assert property (@(posedge clk) disable iff (rst)
    pop |-> nonempty)
    else $error("pop from empty output queue");

endmodule

`default_nettype wire

// ----- sv/utf8_to_utf16_strict_decoder.sv -----
`default_nettype none

// A byte passes the input stage register and the result queue before its first unit.
// Throughput: 1 byte per cycle while the queue has room for a pair; a code point gives
//   one unit, a pair two; the 4-entry result queue absorbs the second unit of a pair.
// Output rate is set by the single result port: one unit per cycle unless unit_stall.
// Reset (rst, synchronous): empties the input stage and result queue and
//   returns the decoder to idle, not discarding.
module utf8_to_utf16_strict_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  // byte channel
  input  wire logic        data_valid,
  output logic             data_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_string,
  // result channel
  output logic             unit_valid,
  input  wire logic        unit_stall,
  output logic [15:0]      utf16_unit,
  output logic             status,
  output logic             last_unit
);

  // Input stage: holds one byte until the queue can take its results
  logic       pipe_valid;
  logic [7:0] pipe_byte;
  logic       pipe_eos;

  logic                 advance;
  logic                 room2;
  logic                 pop;
  utf8d_pkg::dec_out_t  dout;
  utf8d_pkg::result_t   head;

  // Decode a byte only when the queue has room for a full surrogate pair,
  // so a step never has to be split across cycles.
  assign advance    = pipe_valid && room2;
  // Hold off the sender only while the staged byte cannot move on
  assign data_stall = pipe_valid && !room2;
  assign pop        = unit_valid && !unit_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
    end else if (data_valid && !data_stall) begin
      pipe_valid <= 1'b1;
    end else if (advance) begin
      pipe_valid <= 1'b0;
    end
  end

  // Payload: load on every transfer, no reset needed
  always_ff @(posedge clk) begin
    if (data_valid && !data_stall) begin
      pipe_byte <= data_byte;
      pipe_eos  <= end_of_string;
    end
  end

  // Validate the staged byte and step the sequence state
  utf8d_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .data_byte     (pipe_byte),
    .end_of_string (pipe_eos),
    .dout          (dout)
  );

  // Buffer results so the output side can stall independently
  utf8d_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (advance),
    .din      (dout),
    .pop      (pop),
    .room2    (room2),
    .nonempty (unit_valid),
    .head     (head)
  );

  assign utf16_unit = head.unit;
  assign status     = head.status;
  assign last_unit  = head.last;

  // Invalid results always carry a zero unit and close the string
  assert property (@(posedge clk) disable iff (rst)
    unit_valid && status |-> utf16_unit == 16'h0000 && last_unit)
    else $error("invalid result not zero or not marked last");

  // A byte leaves the input stage only by being decoded
  assert property (@(posedge clk) disable iff (rst)
    pipe_valid && !advance && !(data_valid && !data_stall) |=> pipe_valid &&
      $stable(pipe_byte) && $stable(pipe_eos))
    else $error("staged byte lost or changed");

endmodule

`default_nettype wire
